[rtl/core/ncsw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// package: shared types and constants of the chunk stream walker
package ncsw_pkg;

   localparam logic [31:0] TAG_FORM = 32'h464F524D;
   localparam logic [31:0] TAG_NULL = 32'h4E554C4C;

   localparam logic [2:0] EV_FOLDER  = 3'd0;
   localparam logic [2:0] EV_DATA    = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_ERROR   = 3'd3;
   localparam logic [2:0] EV_END     = 3'd4;

   localparam logic [1:0] FAULT_NONE     = 2'd0;
   localparam logic [1:0] FAULT_BAD_NAME = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd2;
   localparam logic [1:0] FAULT_CUT      = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_SIZE    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_POP   = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   function automatic logic name_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) || c == 8'h20;
   endfunction

endpackage
`default_nettype wire

[rtl/core/nested_chunk_stream_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Chunk stream walker: takes one file byte per item and gives at most one
// event per item. Folder end positions live in a RAM of STACK_DEPTH entries
// with one write and one registered read port. An item passes through
// accept, update and output register steps; the first byte of a header, and
// the last byte of a skipped filler name, add a stack check that pops the
// folders ending at that position. A stalled result holds the block in its
// output step, and no new byte is taken until the result drains.
module nested_chunk_stream_walker #(
   parameter int STACK_DEPTH   = 16,
   parameter int POSITION_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_final_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_event_kind,
   output      logic [4:0]  rsp_nest_depth,
   output      logic [31:0] rsp_name_front,
   output      logic [31:0] rsp_name_back,
   output      logic [3:0]  rsp_name_length,
   output      logic [31:0] rsp_chunk_size,
   output      logic [7:0]  rsp_payload_value,
   output      logic [1:0]  rsp_fault_code,
   output      logic        rsp_stream_done
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PW = POSITION_BITS;

   ncsw_pkg::state_type state_ff, state_in;
   ncsw_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0]    depth_ff, depth_in;
   logic [63:0]   win_ff, win_in;
   logic [3:0]    fill_ff, fill_in;
   logic [31:0]   left_ff, left_in;
   logic          halt_ff, halt_in;
   logic [7:0]    byte_ff, byte_in;
   logic          fin_ff, fin_in;
   logic [PW-1:0] popat_ff, popat_in;
   logic          nullpop_ff, nullpop_in;

   logic        ov_ff, ov_in;
   logic [2:0]  ok_ff, ok_in;
   logic [4:0]  od_ff, od_in;
   logic [31:0] of_ff, of_in, ob_ff, ob_in, os_ff, os_in;
   logic [3:0]  ol_ff, ol_in;
   logic [7:0]  op_ff, op_in;
   logic [1:0]  oc_ff, oc_in;
   logic        oe_ff, oe_in;

   logic          we;
   logic [AW-1:0] wa, ra;
   logic [31:0]   wd, rd;

   ncsw_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   assign req_stall = (state_ff != ncsw_pkg::ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_event_kind = ok_ff;
   assign rsp_nest_depth = od_ff;
   assign rsp_name_front = of_ff;
   assign rsp_name_back = ob_ff;
   assign rsp_name_length = ol_ff;
   assign rsp_chunk_size = os_ff;
   assign rsp_payload_value = op_ff;
   assign rsp_fault_code = oc_ff;
   assign rsp_stream_done = oe_ff;

   logic [63:0] nwin;
   logic [3:0]  nfill, ncnt;
   logic        stop;
   logic [31:0] nleft, front, back, size;
   logic [3:0]  len;
   logic        folder, hdr;
   logic [PW-1:0] fend;

   always_comb begin
      nwin = {win_ff[55:0], byte_ff};
      nfill = fill_ff + 4'd1;
      nleft = {left_ff[23:0], byte_ff};
      ncnt = 4'd0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!stop && ncsw_pkg::name_char(nwin[63-8*i -: 8])) ncnt = ncnt + 4'd1;
         else stop = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; pos_in = pos_ff; cnt_in = cnt_ff;
      depth_in = depth_ff; win_in = win_ff; fill_in = fill_ff; left_in = left_ff;
      halt_in = halt_ff; byte_in = byte_ff; fin_in = fin_ff; popat_in = popat_ff;
      nullpop_in = nullpop_ff;
      ov_in = ov_ff && rsp_stall; ok_in = ok_ff; od_in = od_ff; of_in = of_ff;
      ob_in = ob_ff; os_in = os_ff; ol_in = ol_ff; op_in = op_ff; oc_in = oc_ff;
      oe_in = oe_ff;
      we = 1'b0; wa = cnt_ff[AW-1:0]; wd = 32'd0;
      ra = cnt_ff[AW-1:0] - AW'(1);
      front = 32'd0; back = 32'd0; size = 32'd0; len = 4'd0; folder = 1'b0; hdr = 1'b0;
      fend = '0;
      unique case (state_ff)
         ncsw_pkg::ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_stream_byte;
               fin_in = req_final_byte;
               popat_in = pos_ff;
               nullpop_in = 1'b0;
               // pop check only at the first header byte
               if (!halt_ff && phase_ff == ncsw_pkg::PH_HEADER && fill_ff == 4'd0)
                  state_in = ncsw_pkg::ST_POP;
               else state_in = ncsw_pkg::ST_EXEC;
            end
         end
         ncsw_pkg::ST_POP: begin
            // rd holds the entry below cnt (read issued last cycle)
            if (cnt_ff != '0 && rd[PW-1:0] == popat_ff && nullpop_ff == 1'b1) begin
               cnt_in = cnt_ff - CW'(1);
               depth_in = depth_ff - 5'd1;
               ra = cnt_ff[AW-1:0] - AW'(2);
               nullpop_in = 1'b0;
            end else if (cnt_ff != '0 && nullpop_ff == 1'b0) begin
               nullpop_in = 1'b1;
            end else begin
               // after a filler name the byte is already done
               state_in = (fill_ff == 4'd4) ? ncsw_pkg::ST_OUT : ncsw_pkg::ST_EXEC;
               nullpop_in = 1'b0;
               if (fill_ff == 4'd4 && fin_ff) begin
                  // final byte right after a filler name: header cut short
                  ov_in = 1'b1; ok_in = ncsw_pkg::EV_ERROR; oc_in = ncsw_pkg::FAULT_CUT;
                  od_in = depth_ff; oe_in = 1'b1;
                  of_in = 32'd0; ob_in = 32'd0; ol_in = 4'd0; os_in = 32'd0;
                  op_in = 8'd0;
                  pos_in = '0; cnt_in = '0; depth_in = 5'd1; win_in = 64'd0;
                  fill_in = 4'd0; phase_in = ncsw_pkg::PH_HEADER; left_in = 32'd0;
                  halt_in = 1'b0;
               end
            end
         end
         ncsw_pkg::ST_EXEC: begin
            state_in = ncsw_pkg::ST_OUT;
            ok_in = ncsw_pkg::EV_END; of_in = 32'd0; ob_in = 32'd0; ol_in = 4'd0;
            os_in = 32'd0; op_in = 8'd0; oc_in = ncsw_pkg::FAULT_NONE; oe_in = 1'b0;
            od_in = depth_ff;
            ov_in = 1'b0;
            if (halt_ff) begin
               // nothing
            end else begin
               pos_in = pos_ff + PW'(1);
               unique case (phase_ff)
                  ncsw_pkg::PH_PAYLOAD: begin
                     ov_in = 1'b1; ok_in = ncsw_pkg::EV_PAYLOAD; op_in = byte_ff;
                     left_in = left_ff - 32'd1;
                     if (left_ff == 32'd1) phase_in = ncsw_pkg::PH_HEADER;
                  end
                  ncsw_pkg::PH_SIZE: begin
                     left_in = nleft; fill_in = nfill;
                     if (nfill >= 4'd12) begin
                        hdr = 1'b1; front = win_ff[63:32]; back = win_ff[31:0];
                        len = 4'd8; size = nleft;
                     end
                  end
                  default: begin
                     win_in = nwin; fill_in = nfill;
                     if (nfill >= 4'd8) begin
                        if (ncnt < 4'd4) begin
                           ov_in = 1'b1; ok_in = ncsw_pkg::EV_ERROR;
                           oc_in = ncsw_pkg::FAULT_BAD_NAME; halt_in = 1'b1;
                        end else if (ncnt < 4'd8) begin
                           if (nwin[63:32] == ncsw_pkg::TAG_NULL) begin
                              win_in = {32'd0, nwin[31:0]};
                              fill_in = 4'd4;
                              popat_in = pos_ff - PW'(3);
                              nullpop_in = 1'b0;
                              state_in = ncsw_pkg::ST_POP;
                           end else begin
                              hdr = 1'b1; front = nwin[63:32]; len = 4'd4;
                              size = nwin[31:0];
                           end
                        end else begin
                           phase_in = ncsw_pkg::PH_SIZE; left_in = 32'd0;
                        end
                     end
                  end
               endcase
               if (hdr) begin
                  folder = size >= 32'd4 && (front == ncsw_pkg::TAG_FORM ||
                           (len == 4'd8 && back == ncsw_pkg::TAG_FORM));
                  fill_in = 4'd0; win_in = 64'd0; phase_in = ncsw_pkg::PH_HEADER;
                  ov_in = 1'b1;
                  if (folder && cnt_ff >= CW'(STACK_DEPTH)) begin
                     ok_in = ncsw_pkg::EV_ERROR; oc_in = ncsw_pkg::FAULT_OVERFLOW;
                     halt_in = 1'b1;
                  end else begin
                     of_in = front; ob_in = back; ol_in = len; os_in = size;
                     if (folder) begin
                        ok_in = ncsw_pkg::EV_FOLDER;
                        we = 1'b1;
                        fend = pos_in + size[PW-1:0];
                        wd = 32'(fend);
                        cnt_in = cnt_ff + CW'(1);
                        depth_in = depth_ff + 5'd1;
                     end else begin
                        ok_in = ncsw_pkg::EV_DATA; left_in = size;
                        if (size != 32'd0) phase_in = ncsw_pkg::PH_PAYLOAD;
                     end
                  end
               end
            end
            if (state_in == ncsw_pkg::ST_POP) ov_in = 1'b0;
            // a final byte that ends a filler name is finished after its pops
            if (fin_ff && state_in != ncsw_pkg::ST_POP) begin
               state_in = ncsw_pkg::ST_OUT;
               oe_in = 1'b1;
               if (!halt_ff && !halt_in && (phase_in == ncsw_pkg::PH_SIZE ||
                   (phase_in == ncsw_pkg::PH_HEADER && fill_in != 4'd0))) begin
                  ov_in = 1'b1; ok_in = ncsw_pkg::EV_ERROR; oc_in = ncsw_pkg::FAULT_CUT;
                  of_in = 32'd0; ob_in = 32'd0; ol_in = 4'd0; os_in = 32'd0;
                  op_in = 8'd0;
               end else if (!ov_in) begin
                  ov_in = 1'b1; ok_in = ncsw_pkg::EV_END;
               end
               pos_in = '0; cnt_in = '0; depth_in = 5'd1; win_in = 64'd0;
               fill_in = 4'd0; phase_in = ncsw_pkg::PH_HEADER; left_in = 32'd0;
               halt_in = 1'b0;
            end
         end
         default: begin
            // wait for the output register to drain
            if (!ov_ff || !rsp_stall) state_in = ncsw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ncsw_pkg::ST_IDLE; phase_ff <= ncsw_pkg::PH_HEADER;
         pos_ff <= '0; cnt_ff <= '0; depth_ff <= 5'd1; win_ff <= 64'd0;
         fill_ff <= 4'd0; left_ff <= 32'd0; halt_ff <= 1'b0; ov_ff <= 1'b0;
         nullpop_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; pos_ff <= pos_in;
         cnt_ff <= cnt_in; depth_ff <= depth_in; win_ff <= win_in;
         fill_ff <= fill_in; left_ff <= left_in; halt_ff <= halt_in; ov_ff <= ov_in;
         nullpop_ff <= nullpop_in;
      end
      byte_ff <= byte_in; fin_ff <= fin_in; popat_ff <= popat_in;
      ok_ff <= ok_in; od_ff <= od_in; of_ff <= of_in; ob_ff <= ob_in;
      os_ff <= os_in; ol_ff <= ol_in; op_ff <= op_in; oc_ff <= oc_in; oe_ff <= oe_in;
   end
endmodule
`default_nettype wire

[rtl/core/ncsw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// generic ram with one write port and one registered read port
module ncsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
